// File: src/obrb_pkg.sv
// Shared types and defaults for the overwriting byte ring buffer.
`default_nettype none

package obrb_pkg;

    localparam int DEPTH_DEF    = 256;
    localparam int MAX_READ_DEF = 64;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_PEEK  = 2'd1,
        OP_POP   = 2'd2,
        OP_DMA   = 2'd3
    } op_t;

    // One classified request as it waits in the command queue.
    typedef struct packed {
        op_t        kind;
        logic [7:0] data;
        logic [6:0] req;
        logic [7:0] np;
    } cmd_t;

    // Status reported by the back part to the front part.
    typedef struct packed {
        logic clr_busy;
    } back_status_t;

endpackage

`default_nettype wire

// File: src/obrb_front.sv
// Front part: accepts requests, classifies them and holds them in a two-entry queue.
`default_nettype none

module obrb_front
    import obrb_pkg::*;
#(
    parameter int MAX_READ = MAX_READ_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [23:0]  s_tdata,   // data_byte[7:0], request_count[14:8], new_write_index[22:15]
    input  wire logic [1:0]   s_tuser,   // opcode[1:0]
    input  wire back_status_t status,
    output cmd_t              cmd,
    output logic              cmd_valid,
    input  wire logic         cmd_pop
);

    cmd_t       q_reg [2];
    logic       q_wp_reg, q_wp_next;
    logic       q_rp_reg, q_rp_next;
    logic [1:0] q_cnt_reg, q_cnt_next;
    cmd_t       in_cmd;
    logic       push;

    always_comb begin
        in_cmd.kind = op_t'(s_tuser[1:0]);
        in_cmd.data = s_tdata[7:0];
        in_cmd.np   = s_tdata[22:15];
        // Requests above the per-read limit are cut down here.
        if (s_tdata[14:8] > 7'(MAX_READ)) begin
            in_cmd.req = 7'(MAX_READ);
        end else begin
            in_cmd.req = s_tdata[14:8];
        end
    end

    assign s_tready  = (q_cnt_reg != 2'd2) && !status.clr_busy;
    assign push      = s_tvalid && s_tready;
    assign cmd_valid = (q_cnt_reg != 2'd0);
    assign cmd       = q_reg[q_rp_reg];

    always_comb begin
        q_wp_next  = push ? ~q_wp_reg : q_wp_reg;
        q_rp_next  = cmd_pop ? ~q_rp_reg : q_rp_reg;
        q_cnt_next = q_cnt_reg + 2'(push) - 2'(cmd_pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[q_wp_reg] <= in_cmd;
        end
        if (!aresetn) begin
            q_wp_reg  <= 1'b0;
            q_rp_reg  <= 1'b0;
            q_cnt_reg <= 2'd0;
        end else begin
            q_wp_reg  <= q_wp_next;
            q_rp_reg  <= q_rp_next;
            q_cnt_reg <= q_cnt_next;
        end
    end

endmodule

`default_nettype wire

// File: src/obrb_back.sv
// Back part: ring indexes, byte store and the read sequencer with its output register.
`default_nettype none

module obrb_back
    import obrb_pkg::*;
#(
    parameter int DEPTH    = DEPTH_DEF,
    parameter int MAX_READ = MAX_READ_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [8:0]  cfg_wr_data,
    input  wire cmd_t        cmd,
    input  wire logic        cmd_valid,
    output logic             cmd_pop,
    output back_status_t     status,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,
    output logic             m_tuser,
    output logic             m_tlast
);

    // The capacity setting is nine bits wide, so no more than 511 slots are ever used.
    localparam int CAP_MAX = (DEPTH < 511) ? DEPTH : 511;
    localparam int CAP_RST = (CAP_MAX < 256) ? CAP_MAX : 256;
    localparam int IDX_W   = $clog2(CAP_MAX);
    localparam int CAP_W   = $clog2(CAP_MAX + 1);
    localparam int CMP_W   = (CAP_W > 8) ? CAP_W : 8;
    localparam int MIN_W   = (IDX_W > 7) ? IDX_W : 7;
    localparam int CNT_W   = (IDX_W > 8) ? IDX_W : 8;
    localparam int RCNT_W  = $clog2(MAX_READ + 1);

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i,
                                                  input logic [CAP_W-1:0] c);
        logic [CAP_W-1:0] s;
        s = CAP_W'(i) + CAP_W'(1);
        return (s == c) ? '0 : s[IDX_W-1:0];
    endfunction

    function automatic logic [7:0] sat8(input logic [IDX_W-1:0] v);
        logic [CNT_W-1:0] e;
        e = CNT_W'(v);
        return (e > CNT_W'(255)) ? 8'hFF : e[7:0];
    endfunction

    function automatic logic [CAP_W-1:0] clamp_cap(input logic [8:0] v);
        logic [CAP_W-1:0] r;
        if (v < 9'd2) begin
            r = CAP_W'(2);
        end else if ({1'b0, v} > 10'(CAP_MAX)) begin
            r = CAP_W'(CAP_MAX);
        end else begin
            r = CAP_W'(v);
        end
        return r;
    endfunction

    logic [7:0]        mem [CAP_MAX];
    logic [7:0]        rdata_reg;
    logic              mem_we, mem_re;
    logic [IDX_W-1:0]  mem_waddr, mem_raddr;
    logic [7:0]        mem_wdata;

    state_t            state_reg, state_next;
    logic [CAP_W-1:0]  cap_reg, cap_next;
    logic [IDX_W-1:0]  wr_reg, wr_next;
    logic [IDX_W-1:0]  rd_reg, rd_next;
    logic              clr_busy_reg, clr_busy_next;
    logic [IDX_W-1:0]  clr_idx_reg, clr_idx_next;
    logic [IDX_W-1:0]  iss_idx_reg, iss_idx_next;
    logic [RCNT_W-1:0] iss_left_reg, iss_left_next;
    logic [RCNT_W-1:0] dlv_left_reg, dlv_left_next;
    logic              pend_reg, pend_next;
    logic              is_pop_reg, is_pop_next;
    logic [IDX_W-1:0]  used_reg, used_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_byte_reg, out_byte_next;
    logic              out_last_reg, out_last_next;
    logic              out_empty_reg, out_empty_next;
    logic [7:0]        out_used_reg, out_used_next;

    logic [IDX_W-1:0]  used_now;
    logic [CAP_W-1:0]  used_sum;
    logic [MIN_W-1:0]  n_wide;
    logic [RCNT_W-1:0] n_cnt;
    logic              out_free;
    logic              np_ok;
    logic [IDX_W-1:0]  np_idx;
    logic [CAP_W-1:0]  fwd;
    logic [CAP_W:0]    total;
    logic [IDX_W-1:0]  wr_inc;
    logic              deliver, issue;
    logic [IDX_W-1:0]  used_after;

    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        if (wr_reg >= rd_reg) begin
            used_sum = CAP_W'(wr_reg) - CAP_W'(rd_reg);
        end else begin
            used_sum = CAP_W'(wr_reg) + cap_reg - CAP_W'(rd_reg);
        end
        used_now = used_sum[IDX_W-1:0];

        if (MIN_W'(cmd.req) < MIN_W'(used_now)) begin
            n_wide = MIN_W'(cmd.req);
        end else begin
            n_wide = MIN_W'(used_now);
        end
        n_cnt = RCNT_W'(n_wide);

        np_ok  = CMP_W'(cmd.np) < CMP_W'(cap_reg);
        np_idx = IDX_W'(cmd.np);
        if (np_idx >= wr_reg) begin
            fwd = CAP_W'(np_idx) - CAP_W'(wr_reg);
        end else begin
            fwd = CAP_W'(np_idx) + cap_reg - CAP_W'(wr_reg);
        end
        total  = (CAP_W + 1)'(used_now) + (CAP_W + 1)'(fwd);
        wr_inc = wrap_inc(wr_reg, cap_reg);
    end

    always_comb begin
        state_next     = state_reg;
        cap_next       = cap_reg;
        wr_next        = wr_reg;
        rd_next        = rd_reg;
        clr_busy_next  = clr_busy_reg;
        clr_idx_next   = clr_idx_reg;
        iss_idx_next   = iss_idx_reg;
        iss_left_next  = iss_left_reg;
        dlv_left_next  = dlv_left_reg;
        pend_next      = pend_reg;
        is_pop_next    = is_pop_reg;
        used_next      = used_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_empty_next = out_empty_reg;
        out_used_next  = out_used_reg;
        cmd_pop        = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = wr_reg;
        mem_wdata      = cmd.data;
        mem_re         = 1'b0;
        mem_raddr      = rd_reg;
        deliver        = 1'b0;
        issue          = 1'b0;
        used_after     = used_reg;

        // After reset the store is swept to zero, one slot per cycle.
        if (clr_busy_reg) begin
            mem_we       = 1'b1;
            mem_waddr    = clr_idx_reg;
            mem_wdata    = 8'd0;
            clr_idx_next = clr_idx_reg + IDX_W'(1);
            if (clr_idx_reg == IDX_W'(CAP_MAX - 1)) begin
                clr_busy_next = 1'b0;
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid && !clr_busy_reg) begin
                    case (cmd.kind)
                        OP_WRITE: begin
                            cmd_pop = 1'b1;
                            mem_we  = 1'b1;
                            wr_next = wr_inc;
                            // A full ring drops its oldest byte.
                            if (wr_inc == rd_reg) begin
                                rd_next = wrap_inc(rd_reg, cap_reg);
                            end
                        end
                        OP_DMA: begin
                            cmd_pop = 1'b1;
                            if (np_ok) begin
                                wr_next = np_idx;
                                if (total >= (CAP_W + 1)'(cap_reg)) begin
                                    rd_next = wrap_inc(np_idx, cap_reg);
                                end
                            end
                        end
                        default: begin
                            if (n_cnt == '0) begin
                                if (out_free) begin
                                    cmd_pop        = 1'b1;
                                    out_valid_next = 1'b1;
                                    out_byte_next  = 8'd0;
                                    out_last_next  = 1'b1;
                                    out_empty_next = 1'b1;
                                    out_used_next  = sat8(used_now);
                                end
                            end else begin
                                cmd_pop       = 1'b1;
                                mem_re        = 1'b1;
                                mem_raddr     = rd_reg;
                                iss_idx_next  = wrap_inc(rd_reg, cap_reg);
                                iss_left_next = n_cnt - RCNT_W'(1);
                                dlv_left_next = n_cnt;
                                pend_next     = 1'b1;
                                is_pop_next   = (cmd.kind == OP_POP);
                                used_next     = used_now;
                                state_next    = ST_READ;
                            end
                        end
                    endcase
                end
            end
            ST_READ: begin
                deliver = pend_reg && out_free;
                // Reading overwrites the read register, so the held byte must leave first.
                issue   = (iss_left_reg != '0) && (!pend_reg || out_free);
                if (issue) begin
                    mem_re        = 1'b1;
                    mem_raddr     = iss_idx_reg;
                    iss_idx_next  = wrap_inc(iss_idx_reg, cap_reg);
                    iss_left_next = iss_left_reg - RCNT_W'(1);
                end
                pend_next = issue ? 1'b1 : (deliver ? 1'b0 : pend_reg);
                if (deliver) begin
                    used_after     = is_pop_reg ? used_reg - IDX_W'(1) : used_reg;
                    used_next      = used_after;
                    out_valid_next = 1'b1;
                    out_byte_next  = rdata_reg;
                    out_last_next  = (dlv_left_reg == RCNT_W'(1));
                    out_empty_next = 1'b0;
                    out_used_next  = sat8(used_after);
                    dlv_left_next  = dlv_left_reg - RCNT_W'(1);
                    if (is_pop_reg) begin
                        rd_next = wrap_inc(rd_reg, cap_reg);
                    end
                    if (dlv_left_reg == RCNT_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Configuration must arrive only while the block is idle; the block itself does not enforce it.
        if (cfg_wr_en) begin
            cap_next = clamp_cap(cfg_wr_data);
            wr_next  = '0;
            rd_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        iss_idx_reg   <= iss_idx_next;
        iss_left_reg  <= iss_left_next;
        dlv_left_reg  <= dlv_left_next;
        is_pop_reg    <= is_pop_next;
        used_reg      <= used_next;
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
        out_empty_reg <= out_empty_next;
        out_used_reg  <= out_used_next;
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cap_reg       <= CAP_W'(CAP_RST);
            wr_reg        <= '0;
            rd_reg        <= '0;
            clr_busy_reg  <= 1'b1;
            clr_idx_reg   <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cap_reg       <= cap_next;
            wr_reg        <= wr_next;
            rd_reg        <= rd_next;
            clr_busy_reg  <= clr_busy_next;
            clr_idx_reg   <= clr_idx_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign status.clr_busy = clr_busy_reg;
    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = {out_used_reg, out_byte_reg};
    assign m_tuser         = out_empty_reg;
    assign m_tlast         = out_last_reg;

endmodule

`default_nettype wire

// File: src/overwrite_byte_ring_buffer.sv
// Top level of the overwriting byte ring buffer: front queue and back sequencer.
// A request is registered in the queue before the back part sees it, so one request per cycle
// is taken while the queue has room and the store clear is not running.
// A read of n bytes holds the back part for a store read start, then one byte per cycle from the
// single read port while m_tready allows; its first byte passes the read and output registers.
// After reset the store is cleared to zero with s_tready held low.
`default_nettype none

module overwrite_byte_ring_buffer
    import obrb_pkg::*;
#(
    parameter int DEPTH    = DEPTH_DEF,
    parameter int MAX_READ = MAX_READ_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [8:0]  cfg_wr_data,  // capacity[8:0]
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,      // data_byte[7:0], request_count[14:8], new_write_index[22:15]
    input  wire logic [1:0]  s_tuser,      // opcode[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,      // read_byte[7:0], used_count[15:8]
    output logic             m_tuser,      // empty_res
    output logic             m_tlast
);

    cmd_t         cmd;
    logic         cmd_valid;
    logic         cmd_pop;
    back_status_t status;

    obrb_front #(
        .MAX_READ (MAX_READ)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .status    (status),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop)
    );

    obrb_back #(
        .DEPTH    (DEPTH),
        .MAX_READ (MAX_READ)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .cmd_valid   (cmd_valid),
        .cmd_pop     (cmd_pop),
        .status      (status),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

`default_nettype wire
